[hw/rtl/orlr_pkg.sv]
// ----------------------------------------------------------------------------
// orlr_pkg: shared types and constants for the overwriting ring log reader.
// Holds the transaction structs, the command codes and the control and
// status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package orlr_pkg;

	// Default sizes of the ring store and of one read burst.
	localparam int DEPTH_DEF       = 64;
	localparam int RECORD_BITS_DEF = 64;
	localparam int MAX_BURST_DEF   = 32;

	// Records kept clear behind the newest one for the in-flight write window.
	localparam int WRITE_MARGIN = 8;

	// Command codes of an input transaction.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// One input transaction.
	typedef struct packed {
		logic        command;
		logic [63:0] write_data;
		logic [63:0] target_index;
		logic [5:0]  requested_count;
	} req_t;

	// One result transaction.
	typedef struct packed {
		logic [63:0] entry_data;
		logic        entry_valid;
		logic [5:0]  copied_count;
		logic [63:0] next_index;
		logic        last;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr;
		logic load;
		logic calc1;
		logic calc2;
		logic calc3;
		logic prime;
		logic emit_none;
		logic emit_zero;
		logic emit_rec;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic avail;
		logic n_zero;
		logic last_rec;
	} ctrl_stat_t;

endpackage

[hw/rtl/orlr_ctrl.sv]
// ----------------------------------------------------------------------------
// orlr_ctrl: sequencing state machine of the ring log reader.
// Takes writes in place, walks a read through three set-up steps and a
// read-ahead step, then streams one record per cycle until the burst ends.
// ----------------------------------------------------------------------------
module orlr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   command,
	input  orlr_pkg::ctrl_stat_t   stat,
	output orlr_pkg::ctrl_cmd_t    cmd,
	output logic                   busy
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CALC1  = 3'd1;
	localparam logic [2:0] ST_CALC2  = 3'd2;
	localparam logic [2:0] ST_CALC3  = 3'd3;
	localparam logic [2:0] ST_PRIME  = 3'd4;
	localparam logic [2:0] ST_STREAM = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign busy = (state_q != ST_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == orlr_pkg::CMD_READ) begin
						cmd.load = 1'b1;
						state_nx = ST_CALC1;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_CALC1: begin
				cmd.calc1 = 1'b1;
				state_nx  = ST_CALC2;
			end
			ST_CALC2: begin
				if (!stat.avail) begin
					cmd.emit_none = 1'b1;
					state_nx      = ST_IDLE;
				end else begin
					cmd.calc2 = 1'b1;
					state_nx  = ST_CALC3;
				end
			end
			ST_CALC3: begin
				cmd.calc3 = 1'b1;
				state_nx  = ST_PRIME;
			end
			ST_PRIME: begin
				if (stat.n_zero) begin
					cmd.emit_zero = 1'b1;
					state_nx      = ST_IDLE;
				end else begin
					cmd.prime = 1'b1;
					state_nx  = ST_STREAM;
				end
			end
			ST_STREAM: begin
				cmd.emit_rec = 1'b1;
				if (stat.last_rec) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

[hw/rtl/orlr_dp.sv]
// ----------------------------------------------------------------------------
// orlr_dp: datapath of the ring log reader.
// Holds the record memory, the running sequence count and the clamping
// arithmetic, and drives the registered result transaction.
// ----------------------------------------------------------------------------
module orlr_dp #(
	parameter int DEPTH       = orlr_pkg::DEPTH_DEF,
	parameter int RECORD_BITS = orlr_pkg::RECORD_BITS_DEF,
	parameter int MAX_BURST   = orlr_pkg::MAX_BURST_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  orlr_pkg::req_t       request,
	input  orlr_pkg::ctrl_cmd_t  cmd,
	output orlr_pkg::ctrl_stat_t stat,
	output orlr_pkg::rsp_t       response,
	output logic                 response_valid
);

	localparam int AW  = $clog2(DEPTH);
	localparam int NW  = $clog2(MAX_BURST + 1);
	localparam int CW  = (AW + 1 > NW) ? AW + 1 : NW;
	localparam int LIM = DEPTH - 1 - orlr_pkg::WRITE_MARGIN;

	// Record memory; entries are only read after they were written.
	logic [RECORD_BITS-1:0] mem [DEPTH];
	logic [RECORD_BITS-1:0] rd_q;
	logic [AW-1:0]          rd_addr;

	logic [63:0]   wc_q;
	logic [AW-1:0] wr_slot_q;
	logic [63:0]   target_q;
	logic [NW-1:0] wanted_q;
	logic          avail_q;
	logic [63:0]   back_raw_q;
	logic [63:0]   newest_q;
	logic [AW-1:0] back_q;
	logic [NW-1:0] n_q;
	logic [63:0]   start_q;
	logic [AW-1:0] start_slot_q;
	logic [AW-1:0] addr_q;
	logic [63:0]   next_q;
	logic [NW-1:0] cnt_q;
	orlr_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	logic [NW-1:0] wanted_sat;
	logic [AW-1:0] back_lim;
	logic [AW-1:0] back_sel;
	logic [CW-1:0] back_inc;
	logic [NW-1:0] n_sel;
	logic [AW:0]   slot_sum;
	logic [AW-1:0] slot_sel;
	logic [NW-1:0] cnt_inc;

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		slot_inc = (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
	endfunction

	// Wanted count saturates at the burst limit.
	assign wanted_sat = (int'(request.requested_count) > MAX_BURST) ?
		NW'(MAX_BURST) : NW'(request.requested_count);

	// Clamp how far back the read may start, then bound the burst length.
	assign back_lim = (back_raw_q > 64'(LIM)) ? AW'(LIM) : back_raw_q[AW-1:0];
	assign back_sel = ((newest_q[63:AW] == '0) && (newest_q[AW-1:0] < back_lim)) ?
		newest_q[AW-1:0] : back_lim;
	assign back_inc = CW'(back_sel) + CW'(1);
	assign n_sel    = (back_inc < CW'(wanted_q)) ? NW'(back_inc) : wanted_q;

	// Slot of the start record: newest slot minus the distance back, wrapped.
	assign slot_sum = (AW+1)'(wr_slot_q) + (AW+1)'(DEPTH - 1) - (AW+1)'(back_q);
	assign slot_sel = (slot_sum >= (AW+1)'(DEPTH)) ?
		AW'(slot_sum - (AW+1)'(DEPTH)) : AW'(slot_sum);

	assign cnt_inc = cnt_q + NW'(1);
	assign rd_addr = cmd.prime ? start_slot_q : addr_q;

	assign stat.avail    = avail_q;
	assign stat.n_zero   = (n_q == '0);
	assign stat.last_rec = (cnt_inc == n_q);

	assign response       = rsp_q;
	assign response_valid = rsp_valid_q;

	// Memory write port and registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_slot_q] <= request.write_data[RECORD_BITS-1:0];
		end
		rd_q <= mem[rd_addr];
	end

	// Sequence count and write slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q      <= '0;
			wr_slot_q <= '0;
		end else if (cmd.wr) begin
			wc_q      <= wc_q + 64'd1;
			wr_slot_q <= slot_inc(wr_slot_q);
		end
	end

	// Read set-up and streaming registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			target_q <= request.target_index;
			wanted_q <= wanted_sat;
		end
		if (cmd.calc1) begin
			avail_q    <= (target_q < wc_q);
			back_raw_q <= wc_q + ~target_q;
			newest_q   <= wc_q - 64'd1;
		end
		if (cmd.calc2) begin
			back_q <= back_sel;
			n_q    <= n_sel;
		end
		if (cmd.calc3) begin
			start_q      <= newest_q - 64'(back_q);
			start_slot_q <= slot_sel;
			cnt_q        <= '0;
		end
		if (cmd.prime) begin
			addr_q <= slot_inc(start_slot_q);
			next_q <= start_q + 64'd1;
		end
		if (cmd.emit_rec) begin
			addr_q <= slot_inc(addr_q);
			next_q <= next_q + 64'd1;
			cnt_q  <= cnt_inc;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_none) begin
			rsp_q.entry_data   <= '0;
			rsp_q.entry_valid  <= 1'b0;
			rsp_q.copied_count <= '0;
			rsp_q.next_index   <= target_q;
			rsp_q.last         <= 1'b1;
		end else if (cmd.emit_zero) begin
			rsp_q.entry_data   <= '0;
			rsp_q.entry_valid  <= 1'b0;
			rsp_q.copied_count <= '0;
			rsp_q.next_index   <= start_q;
			rsp_q.last         <= 1'b1;
		end else if (cmd.emit_rec) begin
			rsp_q.entry_data   <= 64'(rd_q);
			rsp_q.entry_valid  <= 1'b1;
			rsp_q.copied_count <= 6'(cnt_inc);
			rsp_q.next_index   <= next_q;
			rsp_q.last         <= stat.last_rec;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= cmd.emit_none | cmd.emit_zero | cmd.emit_rec;
		end
	end

	// A streamed record never goes past the burst length.
	a_cnt_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_rec |-> (cnt_q < n_q))
		else $error("record streamed beyond burst length");

endmodule

[hw/rtl/overwriting_ring_log_reader_unit.sv]
// ----------------------------------------------------------------------------
// overwriting_ring_log_reader_unit: ring log of records with a read port.
// Top level joining the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
// A transaction on request is taken at a rising edge where start is high and
// busy is low. A write (command = write) stores its record and leaves busy
// low, so writes may be issued every cycle; it gives no result.
// A read raises busy for the set-up: a wide compare and subtract, the clamp
// of the start index, the start index itself, and a step to prime the
// registered memory read. With nothing available the single result follows
// the compare step, and the unit is free for a new transaction by then.
// Otherwise results follow the set-up and prime steps, one record per cycle
// from the memory read port, and a read holds the unit through its set-up
// and until its last record is streamed (set-up only when zero are wanted).
// Each result sits on response for exactly one cycle, marked by
// response_valid; the receiver cannot stall it. The final result of a read
// carries last. Reset clears the sequence count; memory contents are left
// as they are and only slots already written are ever read.
// ----------------------------------------------------------------------------
module overwriting_ring_log_reader_unit #(
	parameter int DEPTH       = orlr_pkg::DEPTH_DEF,
	parameter int RECORD_BITS = orlr_pkg::RECORD_BITS_DEF,
	parameter int MAX_BURST   = orlr_pkg::MAX_BURST_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  orlr_pkg::req_t request,
	output orlr_pkg::rsp_t response,
	output logic           response_valid
);

	orlr_pkg::ctrl_cmd_t  cmd;
	orlr_pkg::ctrl_stat_t stat;

	// Sequencer.
	orlr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	// Storage and arithmetic.
	orlr_dp #(
		.DEPTH       (DEPTH),
		.RECORD_BITS (RECORD_BITS),
		.MAX_BURST   (MAX_BURST)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.request        (request),
		.cmd            (cmd),
		.stat           (stat),
		.response       (response),
		.response_valid (response_valid)
	);

	// Results only come out of read activity.
	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		response_valid |-> $past(busy))
		else $error("result without a read in progress");

	// An empty result always ends its read.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(response_valid && !response.entry_valid) |-> response.last)
		else $error("empty result not marked last");

	// After the last result the next read needs set-up time.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(response_valid && response.last) |=> !response_valid)
		else $error("result directly after last");

endmodule

[tb/overwriting_ring_log_reader_unit_tb.sv]
// ----------------------------------------------------------------------------
// overwriting_ring_log_reader_unit_tb: self-checking bench for the ring log.
// A short table of directed transactions covers the empty log, the extreme
// indexes and counts, wrap-around of the store and the clamp of old start
// indexes. Random writes and reads follow. Every result is checked against a
// local model of the ring store and its sequence count, or a known table row.
// ----------------------------------------------------------------------------
module overwriting_ring_log_reader_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = orlr_pkg::DEPTH_DEF;
	localparam int RECORD_BITS = orlr_pkg::RECORD_BITS_DEF;
	localparam int MAX_BURST   = orlr_pkg::MAX_BURST_DEF;
	localparam logic [63:0] REC_MASK = {64{1'b1}} >> (64 - RECORD_BITS);
	localparam int RANDOM_ITEMS = 160;
	localparam int MAX_GAP      = 6;
	localparam int DRAIN_CYCLES = 48;
	localparam int PRINT_LIMIT  = 30;

	// One row of the directed table; known rows carry their single result.
	typedef struct {
		orlr_pkg::req_t rq;
		int             reps;
		bit             known;
		logic [63:0]    known_next;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	orlr_pkg::req_t request;
	orlr_pkg::rsp_t response;
	logic response_valid;

	// Model of the log: sequence count and ring of records.
	logic [63:0] model_count;
	logic [63:0] model_slots [DEPTH];

	orlr_pkg::rsp_t pending_entries [$];
	int   accept_count;
	int   error_count;
	int   results_seen;
	int   writes_sent;
	int   reads_sent;
	bit   no_idle;

	overwriting_ring_log_reader_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.response(response),
		.response_valid(response_valid)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the unit hangs.
	initial begin
		#2ms;
		$display("Timeout with %0d results still expected.", pending_entries.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// Prints one mismatch line, up to a limit, and counts every one.
	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		end
	endtask

	// Applies one transaction to the model and queues the results it causes.
	task automatic log_predict(input orlr_pkg::req_t rq);
		logic [63:0] newest;
		logic [63:0] back;
		logic [63:0] first;
		logic [63:0] wanted;
		logic [63:0] span;
		logic [63:0] limit;
		orlr_pkg::rsp_t r;
		limit = 64'(DEPTH - 1 - orlr_pkg::WRITE_MARGIN);
		if (rq.command == orlr_pkg::CMD_WRITE) begin
			model_slots[int'(model_count % DEPTH)] = rq.write_data & REC_MASK;
			model_count = model_count + 64'd1;
			return;
		end
		r = '0;
		r.last = 1'b1;
		// Nothing written at or past the asked index yet.
		if (!(rq.target_index < model_count)) begin
			r.next_index = rq.target_index;
			pending_entries.push_back(r);
			return;
		end
		// Pull an old start forward, never before the first record.
		newest = model_count - 64'd1;
		back = newest - rq.target_index;
		if (back > limit) back = limit;
		if (back > newest) back = newest;
		first = newest - back;
		wanted = {58'd0, rq.requested_count};
		if (wanted > 64'(MAX_BURST)) wanted = 64'(MAX_BURST);
		span = back + 64'd1;
		if (span > wanted) span = wanted;
		if (span == 0) begin
			r.next_index = first;
			pending_entries.push_back(r);
			return;
		end
		for (longint unsigned k = 0; k < span; k++) begin
			r.entry_data   = model_slots[int'((first + k) % DEPTH)];
			r.entry_valid  = 1'b1;
			r.copied_count = 6'(k + 1);
			r.next_index   = first + k + 64'd1;
			r.last         = (k + 1 == span);
			pending_entries.push_back(r);
		end
	endtask

	// Drives one transaction after a random gap, or none under no_idle, and waits until it is taken.
	task automatic drive_transaction(input orlr_pkg::req_t rq, input bit known,
		input logic [63:0] known_next);
		int gap;
		int seen;
		orlr_pkg::rsp_t r;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		request <= rq;
		seen = accept_count;
		do @(negedge clk); while (accept_count == seen);
		if (rq.command == orlr_pkg::CMD_WRITE) writes_sent++;
		else reads_sent++;
		if (known) begin
			r = '0;
			r.last = 1'b1;
			r.next_index = known_next;
			pending_entries.push_back(r);
		end else begin
			log_predict(rq);
		end
	endtask

	function automatic dir_row_t row_write(input logic [63:0] data, input int reps);
		dir_row_t d;
		d.rq = '0;
		d.rq.command = orlr_pkg::CMD_WRITE;
		d.rq.write_data = data;
		d.reps = reps;
		d.known = 1'b0;
		d.known_next = '0;
		return d;
	endfunction

	function automatic dir_row_t row_read(input logic [63:0] target, input logic [5:0] count);
		dir_row_t d;
		d.rq = '0;
		d.rq.command = orlr_pkg::CMD_READ;
		d.rq.target_index = target;
		d.rq.requested_count = count;
		d.reps = 1;
		d.known = 1'b0;
		d.known_next = '0;
		return d;
	endfunction

	function automatic dir_row_t row_known(input logic [63:0] target, input logic [5:0] count,
		input logic [63:0] next);
		dir_row_t d;
		d = row_read(target, count);
		d.known = 1'b1;
		d.known_next = next;
		return d;
	endfunction

	// Counts accepted transactions and checks every result in order.
	always @(posedge clk) begin
		orlr_pkg::rsp_t want;
		if (arst_n && response_valid) begin
			results_seen++;
			if (pending_entries.size() == 0) begin
				report_mismatch("unexpected result", response.next_index, '0);
			end else begin
				want = pending_entries.pop_front();
				if (response.entry_data !== want.entry_data)
					report_mismatch("entry_data", response.entry_data, want.entry_data);
				if (response.entry_valid !== want.entry_valid)
					report_mismatch("entry_valid", 64'(response.entry_valid),
						64'(want.entry_valid));
				if (response.copied_count !== want.copied_count)
					report_mismatch("copied_count", 64'(response.copied_count),
						64'(want.copied_count));
				if (response.next_index !== want.next_index)
					report_mismatch("next_index", response.next_index, want.next_index);
				if (response.last !== want.last)
					report_mismatch("last", 64'(response.last), 64'(want.last));
			end
		end
		if (arst_n && start && !busy) accept_count++;
	end

	// Stimulus: reset, directed table, random traffic, drain.
	initial begin
		dir_row_t table_rows [$];
		orlr_pkg::req_t rq;
		int sel;
		logic [63:0] reach;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		model_count = '0;
		accept_count = 0;
		error_count = 0;
		results_seen = 0;
		writes_sent = 0;
		reads_sent = 0;
		no_idle = 1'b0;
		for (int i = 0; i < DEPTH; i++) model_slots[i] = '0;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty log, both index extremes, tiny log, zero wanted, saturation.
		table_rows.push_back(row_known(64'd0, 6'd5, 64'd0));
		table_rows.push_back(row_known({64{1'b1}}, 6'd32, {64{1'b1}}));
		table_rows.push_back(row_write(64'd0, 1));
		table_rows.push_back(row_write({64{1'b1}}, 1));
		table_rows.push_back(row_known(64'd0, 6'd0, 64'd0));
		table_rows.push_back(row_read(64'd0, 6'd2));
		table_rows.push_back(row_read(64'd0, 6'd63));
		table_rows.push_back(row_read(64'd1, 6'd1));
		table_rows.push_back(row_known(64'd2, 6'd32, 64'd2));
		// Fill past the depth so the store wraps and old starts are clamped.
		table_rows.push_back(row_write(64'h5A5A_0000_0000_0000, 70));
		table_rows.push_back(row_read(64'd0, 6'd32));
		table_rows.push_back(row_read(64'd16, 6'd63));
		table_rows.push_back(row_read(64'd71, 6'd1));
		table_rows.push_back(row_known(64'd72, 6'd8, 64'd72));
		table_rows.push_back(row_known(64'd0, 6'd0, 64'd16));
		table_rows.push_back(row_write(64'h8000_0000_0000_0001, 1));
		table_rows.push_back(row_read(64'd50, 6'd32));
		table_rows.push_back(row_read(64'd10, 6'd31));
		table_rows.push_back(row_known(64'hFFFF_FFFF_FFFF_FFFE, 6'd1,
			64'hFFFF_FFFF_FFFF_FFFE));

		foreach (table_rows[i]) begin
			for (int rep = 0; rep < table_rows[i].reps; rep++) begin
				rq = table_rows[i].rq;
				if (rq.command == orlr_pkg::CMD_WRITE) rq.write_data = rq.write_data + 64'(rep);
				drive_transaction(rq, table_rows[i].known, table_rows[i].known_next);
			end
		end

		// Random mix of writes and reads, mostly near the newest record.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 30 == 0) no_idle = ($urandom_range(0, 2) == 0);
			rq.command = ($urandom_range(0, 99) < 45) ? orlr_pkg::CMD_WRITE
				: orlr_pkg::CMD_READ;
			rq.write_data = {$urandom, $urandom};
			rq.requested_count = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 3))
				: 6'($urandom_range(0, 63));
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				rq.target_index = {$urandom, $urandom};
			end else if (sel == 1 || model_count == 0) begin
				rq.target_index = model_count + 64'($urandom_range(0, 3));
			end else begin
				reach = (model_count - 1 > 80) ? 64'd80 : model_count - 1;
				rq.target_index = model_count - 1 - 64'($urandom_range(0, int'(reach)));
			end
			drive_transaction(rq, 1'b0, '0);
		end
		start <= 1'b0;

		// Let the last results come out, then watch for strays.
		while (pending_entries.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d writes and %0d reads, log count reached %0d.",
			writes_sent, reads_sent, model_count);
		$display("Compared %0d results, %0d mismatches.", results_seen, error_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
